// ===== rtl/imu_cf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imu_cf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int IN_W  = 16;
  localparam int ANG_W = 32;
  localparam int CNT_W = 16;
  localparam int WGT_W = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd1;

  localparam logic [CNT_W-1:0] CALIB_COUNT_RST  = 16'd1000;
  localparam logic [WGT_W-1:0] BLEND_WEIGHT_RST = 17'd58982;
  localparam logic [WGT_W-1:0] WEIGHT_ONE       = 17'd65536;

  // bias divider: 48-bit dividend, 17-bit divisor, one bit a cycle
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 17;
  localparam int DIV_CNT_W = 6;
  localparam logic [DVS_W-1:0] GYRO_SCALE = 17'd131000;
  // floor(2^48 / 131000), gyro scaling by reciprocal multiply
  localparam logic [31:0] GYRO_RECIP = 32'd2148663944;

  // cordic word widths
  localparam int CX_W       = 27;
  localparam int CZ_W       = 26;
  localparam int ATAN_IDX_W = 5;
  localparam logic signed [CZ_W-1:0] ANGLE_P90 = 26'sd5898240;
  localparam logic signed [CZ_W-1:0] ANGLE_M90 = -26'sd5898240;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_ROLL  = 2'd0;
  localparam axis_t AXIS_YAW   = 2'd1;
  localparam axis_t AXIS_PITCH = 2'd2;

  typedef struct packed {
    logic  load;
    logic  cal_acc;
    logic  div_cal;
    logic  div_gyro;
    logic  bias_wr;
    logic  cordic_start;
    logic  path_wr;
    logic  mix_wr;
    logic  est_wr;
    logic  out_load;
    logic  out_cal;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic calib;
    logic div_busy;
    logic cordic_busy;
  } sts_t;

  // atan(2^-i) in q16.16 degrees
  function automatic logic signed [CZ_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/imu_complementary_angle_filter.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  gyro xyz, accel xyz, elapsed_ms
// out       output     out_valid/out_stall  roll, yaw, pitch (q16.16 deg), calibrating
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time; a calibration item adds to the gyro sums, then runs the
// one-bit-per-cycle bias divider (DVD_W = 48 quotient bits) for each axis in turn
// a filter item takes per axis a cordic run, a reciprocal-multiply gyro scaling
// and the blend steps, axes in turn
// the next item is taken once the result sits in the output register;
// a stalled output holds the block before it loads the next result
// synchronous active-low reset restores config defaults, clears control and estimates
`timescale 1ns / 1ps
`default_nettype none

module imu_complementary_angle_filter
  import imu_cf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [IN_W-1:0] in_gyro_x,
  input  wire logic signed [IN_W-1:0] in_gyro_y,
  input  wire logic signed [IN_W-1:0] in_gyro_z,
  input  wire logic signed [IN_W-1:0] in_accel_x,
  input  wire logic signed [IN_W-1:0] in_accel_y,
  input  wire logic signed [IN_W-1:0] in_accel_z,
  input  wire logic [IN_W-1:0]        in_elapsed_ms,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [ANG_W-1:0]     out_roll_angle,
  output logic signed [ANG_W-1:0]     out_yaw_angle,
  output logic signed [ANG_W-1:0]     out_pitch_angle,
  output logic                        out_calibrating,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  imu_cf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  imu_cf_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_gyro_x       (in_gyro_x),
    .in_gyro_y       (in_gyro_y),
    .in_gyro_z       (in_gyro_z),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_roll_angle  (out_roll_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_calibrating (out_calibrating)
  );

endmodule

`default_nettype wire

// ===== rtl/imu_cf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imu_cf_div
  import imu_cf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DVD_W-1:0]      quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0]     q_r, q_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // restoring long division, dividend shifts out as quotient shifts in
  always_comb begin
    trial    = {rem_r, q_r[DVD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ===== rtl/imu_cf_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imu_cf_cordic
  import imu_cf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [IN_W-1:0] y_in,
  input  wire logic signed [IN_W-1:0] x_in,
  output logic                        busy,
  output logic signed [CZ_W-1:0]      angle
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CX_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys, xi, yi, xsh, ysh;
  logic signed [CZ_W-1:0] z_r, z_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   busy_r, busy_nxt;
  logic                   zero_r;

  assign xi = {{(CX_W-IN_W-8){x_in[IN_W-1]}}, x_in, 8'b0};
  assign yi = {{(CX_W-IN_W-8){y_in[IN_W-1]}}, y_in, 8'b0};
  assign xsh = x_r >>> step_r;
  assign ysh = y_r >>> step_r;

  always_comb begin
    xs       = xi;
    ys       = yi;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      z_nxt = '0;
      // left half plane: turn by a quarter first
      if (xi < 0) begin
        if (yi >= 0) begin
          xs    = yi;
          ys    = -xi;
          z_nxt = ANGLE_P90;
        end else begin
          xs    = -yi;
          ys    = xi;
          z_nxt = ANGLE_M90;
        end
      end
      x_nxt    = xs;
      y_nxt    = ys;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[CX_W-1]) begin
        x_nxt = x_r + ysh;
        y_nxt = y_r - xsh;
        z_nxt = z_r + atan_step(ATAN_IDX_W'(step_r));
      end else begin
        x_nxt = x_r - ysh;
        y_nxt = y_r + xsh;
        z_nxt = z_r - atan_step(ATAN_IDX_W'(step_r));
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (start) begin
      zero_r <= (x_in == '0) && (y_in == '0);
    end
  end

  assign busy  = busy_r;
  assign angle = zero_r ? '0 : z_r;

endmodule

`default_nettype wire

// ===== rtl/imu_cf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imu_cf_dp
  import imu_cf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic signed [IN_W-1:0] in_gyro_x,
  input  wire logic signed [IN_W-1:0] in_gyro_y,
  input  wire logic signed [IN_W-1:0] in_gyro_z,
  input  wire logic signed [IN_W-1:0] in_accel_x,
  input  wire logic signed [IN_W-1:0] in_accel_y,
  input  wire logic signed [IN_W-1:0] in_accel_z,
  input  wire logic [IN_W-1:0]        in_elapsed_ms,
  output logic signed [ANG_W-1:0]     out_roll_angle,
  output logic signed [ANG_W-1:0]     out_yaw_angle,
  output logic signed [ANG_W-1:0]     out_pitch_angle,
  output logic                        out_calibrating
);

  logic signed [IN_W-1:0]  g_r [3];
  logic signed [IN_W-1:0]  a_r [3];
  logic [IN_W-1:0]         dt_r;
  logic signed [IN_W-1:0]  bias_r [3];
  logic signed [ANG_W-1:0] sum_r [3];
  logic signed [ANG_W-1:0] est_r [3];
  logic [CNT_W-1:0]        progress_r;
  logic [CNT_W-1:0]        calib_count_r;
  logic [WGT_W-1:0]        blend_weight_r;
  logic                    neg_r;
  logic signed [ANG_W-1:0] path_r;
  logic signed [51:0]      mix_r;
  logic signed [ANG_W-1:0] roll_r, yaw_r, pitch_r;
  logic                    cal_out_r;
  logic [31:0]             gp_r;
  logic [31:0]             gq_est_r;
  logic [DVD_W-1:0]        gq_prd_r;
  logic [31:0]             gq_r;
  logic [1:0]              gs_stage_r;

  logic signed [IN_W:0]    diff;
  logic [IN_W:0]           diff_neg;
  logic [IN_W-1:0]         dmag;
  logic [31:0]             prod;
  logic [ANG_W-1:0]        smag;
  logic [DVD_W-1:0]        dividend;
  logic [DVS_W-1:0]        divisor;
  logic                    div_busy;
  logic [DVD_W-1:0]        quot;
  logic signed [IN_W-1:0]  cor_y, cor_x;
  logic                    cor_busy;
  logic signed [CZ_W-1:0]  tilt;
  logic signed [33:0]      inc;
  logic signed [35:0]      path_sum;
  logic [WGT_W-1:0]        w_eff;
  logic signed [32:0]      dlt;
  logic signed [50:0]      wprod;
  logic signed [51:0]      mix_sum;
  logic signed [IN_W-1:0]  bias_new;
  logic [63:0]             gq_wide;
  logic [DVD_W-1:0]        gq_rem;

  assign diff     = {g_r[cmd.axis][IN_W-1], g_r[cmd.axis]}
                  - {bias_r[cmd.axis][IN_W-1], bias_r[cmd.axis]};
  assign diff_neg = -diff;
  assign dmag     = diff[IN_W] ? diff_neg[IN_W-1:0] : diff[IN_W-1:0];
  assign prod     = dmag * dt_r;
  assign smag     = sum_r[cmd.axis][ANG_W-1] ? -sum_r[cmd.axis] : sum_r[cmd.axis];
  assign dividend = {16'b0, smag};
  assign divisor  = {1'b0, progress_r};
  assign bias_new = neg_r ? -quot[IN_W-1:0] : quot[IN_W-1:0];

  // gyro scaling prod*65536/131000: reciprocal estimate is exact or one low
  assign gq_wide = {32'b0, gp_r} * {32'b0, GYRO_RECIP};
  assign gq_rem  = {gp_r, 16'b0} - gq_prd_r;

  imu_cf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_cal),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  // roll: atan2(ay,az), yaw: atan2(ax,az), pitch: atan2(ay,ax)
  always_comb begin
    case (cmd.axis)
      AXIS_ROLL: begin
        cor_y = a_r[1];
        cor_x = a_r[2];
      end
      AXIS_YAW: begin
        cor_y = a_r[0];
        cor_x = a_r[2];
      end
      default: begin
        cor_y = a_r[1];
        cor_x = a_r[0];
      end
    endcase
  end

  imu_cf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cordic_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .busy  (cor_busy),
    .angle (tilt)
  );

  assign inc      = neg_r ? -$signed({2'b0, gq_r}) : $signed({2'b0, gq_r});
  assign path_sum = 36'(est_r[cmd.axis]) + 36'(inc);

  // w*path + (1-w)*tilt folded into tilt + w*(path - tilt)
  assign w_eff   = (blend_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_r;
  assign dlt     = 33'(path_r) - 33'(tilt);
  assign wprod   = $signed({1'b0, w_eff}) * dlt;
  assign mix_sum = $signed({{10{tilt[CZ_W-1]}}, tilt, 16'b0}) + 52'(wprod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_count_r  <= CALIB_COUNT_RST;
      blend_weight_r <= BLEND_WEIGHT_RST;
      progress_r     <= '0;
      gs_stage_r     <= '0;
      for (int k = 0; k < 3; k++) begin
        bias_r[k] <= '0;
        sum_r[k]  <= '0;
        est_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CALIB_COUNT:  calib_count_r  <= cfg_data[CNT_W-1:0];
          CFG_BLEND_WEIGHT: blend_weight_r <= cfg_data[WGT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.cal_acc) begin
        progress_r <= progress_r + 1'b1;
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= sum_r[k] + 32'(g_r[k]);
        end
      end
      if (cmd.bias_wr) begin
        bias_r[cmd.axis] <= bias_new;
      end
      if (cmd.est_wr) begin
        est_r[cmd.axis] <= sat32(mix_r[51:16]);
      end
      // three scaling stages, back to idle after the last
      if (cmd.div_gyro) begin
        gs_stage_r <= 2'd1;
      end else if (gs_stage_r != 2'd0) begin
        gs_stage_r <= gs_stage_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r[0] <= in_gyro_x;
      g_r[1] <= in_gyro_y;
      g_r[2] <= in_gyro_z;
      a_r[0] <= in_accel_x;
      a_r[1] <= in_accel_y;
      a_r[2] <= in_accel_z;
      dt_r   <= in_elapsed_ms;
    end
    if (cmd.div_cal) begin
      neg_r <= sum_r[cmd.axis][ANG_W-1];
    end else if (cmd.div_gyro) begin
      neg_r <= diff[IN_W];
    end
    if (cmd.div_gyro) begin
      gp_r <= prod;
    end
    if (gs_stage_r == 2'd1) begin
      gq_est_r <= gq_wide[63:32];
    end
    if (gs_stage_r == 2'd2) begin
      gq_prd_r <= {16'b0, gq_est_r} * {31'b0, GYRO_SCALE};
    end
    if (gs_stage_r == 2'd3) begin
      gq_r <= gq_est_r + {31'b0, gq_rem >= {31'b0, GYRO_SCALE}};
    end
    if (cmd.path_wr) begin
      path_r <= sat32(path_sum);
    end
    if (cmd.mix_wr) begin
      mix_r <= mix_sum;
    end
    if (cmd.out_load) begin
      roll_r    <= cmd.out_cal ? '0 : est_r[0];
      yaw_r     <= cmd.out_cal ? '0 : est_r[1];
      pitch_r   <= cmd.out_cal ? '0 : est_r[2];
      cal_out_r <= cmd.out_cal;
    end
  end

  assign sts.calib       = progress_r < calib_count_r;
  assign sts.div_busy    = div_busy || (gs_stage_r != 2'd0);
  assign sts.cordic_busy = cor_busy;

  assign out_roll_angle  = roll_r;
  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pitch_r;
  assign out_calibrating = cal_out_r;

endmodule

`default_nettype wire

// ===== rtl/imu_cf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imu_cf_ctrl
  import imu_cf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CAL_ACC   = 4'd1;
  localparam logic [3:0] S_CAL_DIV   = 4'd2;
  localparam logic [3:0] S_CAL_WAIT  = 4'd3;
  localparam logic [3:0] S_CAL_BIAS  = 4'd4;
  localparam logic [3:0] S_COR_START = 4'd5;
  localparam logic [3:0] S_COR_WAIT  = 4'd6;
  localparam logic [3:0] S_INC_START = 4'd7;
  localparam logic [3:0] S_INC_WAIT  = 4'd8;
  localparam logic [3:0] S_PATH      = 4'd9;
  localparam logic [3:0] S_MIX       = 4'd10;
  localparam logic [3:0] S_EST       = 4'd11;
  localparam logic [3:0] S_OUT       = 4'd12;

  logic [3:0] state_r, state_nxt;
  axis_t      axis_r, axis_nxt;
  logic       calib_r, calib_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    calib_nxt     = calib_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          axis_nxt  = AXIS_ROLL;
          calib_nxt = sts.calib;
          state_nxt = sts.calib ? S_CAL_ACC : S_COR_START;
        end
      end
      S_CAL_ACC: begin
        cmd.cal_acc = 1'b1;
        state_nxt   = S_CAL_DIV;
      end
      S_CAL_DIV: begin
        cmd.div_cal = 1'b1;
        state_nxt   = S_CAL_WAIT;
      end
      S_CAL_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_CAL_BIAS;
        end
      end
      S_CAL_BIAS: begin
        cmd.bias_wr = 1'b1;
        if (axis_r == AXIS_PITCH) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_CAL_DIV;
        end
      end
      S_COR_START: begin
        cmd.cordic_start = 1'b1;
        state_nxt        = S_COR_WAIT;
      end
      S_COR_WAIT: begin
        if (!sts.cordic_busy) begin
          state_nxt = S_INC_START;
        end
      end
      S_INC_START: begin
        cmd.div_gyro = 1'b1;
        state_nxt    = S_INC_WAIT;
      end
      S_INC_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_PATH;
        end
      end
      S_PATH: begin
        cmd.path_wr = 1'b1;
        state_nxt   = S_MIX;
      end
      S_MIX: begin
        cmd.mix_wr = 1'b1;
        state_nxt  = S_EST;
      end
      S_EST: begin
        cmd.est_wr = 1'b1;
        if (axis_r == AXIS_PITCH) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_COR_START;
        end
      end
      S_OUT: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          cmd.out_cal   = calib_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_ROLL;
      calib_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      calib_r     <= calib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
